@@ design/ppmfd_pkg.sv @@
// Shared constants for the PPM frame decoder.
`timescale 1ns / 1ps
package ppmfd_pkg;

  localparam int TIME_W  = 16;
  localparam int VALUE_W = 15;
  localparam int SLOT_W  = 3;
  localparam int RCH_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request codes
  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IND_THR    = 2'd2;

  // register reset values
  localparam logic [TIME_W-1:0]  SYNC_THR_RST  = 16'd6000;
  localparam logic [VALUE_W-1:0] PULSE_OFS_RST = 15'd1000;
  localparam logic [VALUE_W-1:0] IND_THR_RST   = 15'd700;

endpackage

@@ design/ppm_frame_decoder.sv @@
// PPM frame decoder top level: edge interval decode, double-buffered channel store.
//
// Usage: each input word is either a capture (in_req_type 0) carrying the timer
// value latched at a PPM edge, or a read (in_req_type 1) of one channel from the
// stable half of the channel buffer. Every input word yields one result word.
// A capture measures the interval since the previous edge; above sync_threshold it
// marks frame sync and swaps buffer halves, otherwise the first CHANNELS_PER_HALF
// intervals are halved, offset-corrected and stored. The cfg channel writes the
// three threshold/offset registers; it is always ready and is to be used while
// idle, which the block does not enforce. Each result appears in the cycle after
// its word is accepted. Throughput: one word per cycle when not stalled; the
// channel store is a one-port-write, one-port-read memory with a registered read,
// and decode state sits in flops so consecutive captures chain without a bubble.
// Stall: the output register holds its word while out_ready is low, and in_ready
// drops only while that held word waits, so nothing is lost or repeated.
// Reset (rst_n low, synchronous): registers take their reset values, frame state
// clears, and per-entry valid bits make every buffer slot read as zero until
// written. No clearing pass is needed; the block accepts words right after reset.
`timescale 1ns / 1ps
module ppm_frame_decoder #(
  parameter int CHANNELS_PER_HALF = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [ppmfd_pkg::TIME_W-1:0]     in_capture_time,
  input  logic [ppmfd_pkg::RCH_W-1:0]      in_read_channel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ppmfd_pkg::VALUE_W-1:0]    out_value,
  output logic [ppmfd_pkg::SLOT_W-1:0]     out_slot,
  output logic                             out_written,
  output logic                             out_frame_sync,
  output logic                             out_indicator
);
  import ppmfd_pkg::*;

  localparam int DEPTH  = 2 * CHANNELS_PER_HALF;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(CHANNELS_PER_HALF + 1);
  localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // config registers
  logic [TIME_W-1:0]  sync_thr_r;
  logic [VALUE_W-1:0] pulse_ofs_r;
  logic [VALUE_W-1:0] ind_thr_r;

  // decode state
  logic [TIME_W-1:0] last_time_r, last_time_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              half_r, half_nxt;
  logic              ind_r, ind_nxt;
  logic [DEPTH-1:0]  vld_r, vld_nxt;

  // channel store
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] mem_q_r;

  // output stage
  logic               out_valid_r;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               written_r, written_nxt;
  logic               sync_r, sync_nxt;
  logic               is_rd_r;
  logic               rd_hit_r, rd_hit_nxt;

  logic               accept;
  logic [TIME_W-1:0]  interval;
  logic               is_sync;
  logic [VALUE_W-1:0] halved;
  logic [VALUE_W-1:0] chan_val;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               wr_en;
  logic               rd_en;
  logic               rd_in_range;
  logic [WIDE_W-1:0]  wr_idx_wide;
  logic [WIDE_W-1:0]  rd_idx_wide;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_thr_r  <= SYNC_THR_RST;
      pulse_ofs_r <= PULSE_OFS_RST;
      ind_thr_r   <= IND_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYNC_THR:  sync_thr_r  <= cfg_data;
        REG_PULSE_OFS: pulse_ofs_r <= cfg_data[VALUE_W-1:0];
        REG_IND_THR:   ind_thr_r   <= cfg_data[VALUE_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    interval    = in_capture_time - last_time_r;
    is_sync     = interval > sync_thr_r;
    halved      = interval[TIME_W-1:1];
    chan_val    = (halved < pulse_ofs_r) ? '0 : VALUE_W'(halved - pulse_ofs_r);
    wr_idx      = (half_r ? IDX_W'(CHANNELS_PER_HALF) : '0) + IDX_W'(count_r);
    rd_idx      = (half_r ? '0 : IDX_W'(CHANNELS_PER_HALF)) + IDX_W'(in_read_channel);
    rd_in_range = 32'(in_read_channel) < CHANNELS_PER_HALF;
    wr_idx_wide = WIDE_W'(wr_idx);
    rd_idx_wide = WIDE_W'(rd_idx);

    wr_en = 1'b0;
    rd_en = 1'b0;
    last_time_nxt = last_time_r;
    count_nxt     = count_r;
    half_nxt      = half_r;
    ind_nxt       = ind_r;
    vld_nxt       = vld_r;
    value_nxt     = '0;
    slot_nxt      = '0;
    written_nxt   = 1'b0;
    sync_nxt      = 1'b0;
    rd_hit_nxt    = 1'b0;

    if (in_req_type == REQ_CAPTURE) begin
      last_time_nxt = in_capture_time;
      if (is_sync) begin
        count_nxt = '0;
        half_nxt  = !half_r;
        sync_nxt  = 1'b1;
      end else if (count_r < CNT_W'(CHANNELS_PER_HALF)) begin
        wr_en       = 1'b1;
        count_nxt   = CNT_W'(count_r + 1'b1);
        vld_nxt[wr_idx] = 1'b1;
        value_nxt   = chan_val;
        slot_nxt    = wr_idx_wide[SLOT_W-1:0];
        written_nxt = 1'b1;
        if (count_r == '0) begin
          ind_nxt = chan_val > ind_thr_r;
        end
      end
    end else begin
      if (rd_in_range) begin
        rd_en      = 1'b1;
        slot_nxt   = rd_idx_wide[SLOT_W-1:0];
        rd_hit_nxt = vld_r[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      count_r     <= '0;
      half_r      <= 1'b0;
      ind_r       <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        last_time_r <= last_time_nxt;
        count_r     <= count_nxt;
        half_r      <= half_nxt;
        ind_r       <= ind_nxt;
        vld_r       <= vld_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r   <= value_nxt;
      slot_r    <= slot_nxt;
      written_r <= written_nxt;
      sync_r    <= sync_nxt;
      is_rd_r   <= (in_req_type == REQ_READ);
      rd_hit_r  <= rd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_idx] <= chan_val;
    end
    if (accept && rd_en) begin
      mem_q_r <= mem[rd_idx];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = is_rd_r ? (rd_hit_r ? mem_q_r : '0) : value_r;
  assign out_slot       = slot_r;
  assign out_written    = written_r;
  assign out_frame_sync = sync_r;
  assign out_indicator  = ind_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CHANNELS_PER_HALF)
    else $error("channel count beyond frame size");

  a_sync_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_CAPTURE && is_sync) |=> (count_r == '0 && out_frame_sync))
    else $error("sync edge did not restart frame");

  a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(written_r && (sync_r || is_rd_r)))
    else $error("written flag on sync or read word");
`endif

endmodule

@@ bench/ppm_frame_decoder_chk.sv @@
// Checker for the PPM frame decoder: tracks register writes, predicts each result word and compares.
`timescale 1ns / 1ps
module ppm_frame_decoder_chk #(
  parameter int CHANNELS_PER_HALF = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [ppmfd_pkg::TIME_W-1:0]     in_capture_time,
  input  logic [ppmfd_pkg::RCH_W-1:0]      in_read_channel,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [ppmfd_pkg::VALUE_W-1:0]    out_value,
  input  logic [ppmfd_pkg::SLOT_W-1:0]     out_slot,
  input  logic                             out_written,
  input  logic                             out_frame_sync,
  input  logic                             out_indicator,
  output int                               fail_count,
  output int                               pending_words
);
  import ppmfd_pkg::*;

  localparam int STORE_DEPTH = 2 * CHANNELS_PER_HALF;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
    logic               written;
    logic               frame_sync;
    logic               indicator;
  } ppm_word_t;

  ppm_word_t channel_words_q[$];
  ppm_word_t got_w, want_w, next_w;

  logic [TIME_W-1:0]  sync_thr;
  logic [VALUE_W-1:0] pulse_ofs;
  logic [VALUE_W-1:0] ind_thr;

  logic [TIME_W-1:0]  prev_edge;
  int                 chan_cnt;
  logic               upper_half;
  logic [VALUE_W-1:0] chan_store [STORE_DEPTH];
  logic               ind_lvl;
  int                 word_no;

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  task automatic flag_mismatch(input string msg);
    fail_count++;
    $display("%0t ERROR: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("word %0d %s: got 0x%0h, want 0x%0h", word_no, name, got, want));
  endtask

  task automatic decode_word(input logic req, input logic [TIME_W-1:0] cap,
                             input logic [RCH_W-1:0] rch, output ppm_word_t w);
    logic [TIME_W-1:0]  gap;
    logic [VALUE_W-1:0] half_gap;
    logic [VALUE_W-1:0] v;
    logic               stable_half;
    int                 idx;
    w = '0;
    if (req == REQ_CAPTURE) begin
      gap = cap - prev_edge;
      if (gap > sync_thr) begin
        chan_cnt     = 0;
        upper_half   = ~upper_half;
        w.frame_sync = 1'b1;
      end else if (chan_cnt < CHANNELS_PER_HALF) begin
        half_gap = gap[TIME_W-1:1];
        v = (half_gap < pulse_ofs) ? '0 : half_gap - pulse_ofs;
        idx = int'(upper_half) * CHANNELS_PER_HALF + chan_cnt;
        if (chan_cnt == 0) ind_lvl = (v > ind_thr);
        if (idx < STORE_DEPTH) chan_store[idx] = v;
        chan_cnt++;
        w.value   = v;
        w.slot    = idx[SLOT_W-1:0];
        w.written = 1'b1;
      end
      prev_edge = cap;
    end else if (rch < CHANNELS_PER_HALF) begin
      stable_half = ~upper_half;
      idx = int'(stable_half) * CHANNELS_PER_HALF + int'(rch);
      if (idx < STORE_DEPTH) w.value = chan_store[idx];
      w.slot = idx[SLOT_W-1:0];
    end
    w.indicator = ind_lvl;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_thr   = SYNC_THR_RST;
      pulse_ofs  = PULSE_OFS_RST;
      ind_thr    = IND_THR_RST;
      prev_edge  = '0;
      chan_cnt   = 0;
      upper_half = 1'b0;
      ind_lvl    = 1'b0;
      foreach (chan_store[i]) chan_store[i] = '0;
      channel_words_q.delete();
      word_no = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_THR:  sync_thr  = cfg_data;
          REG_PULSE_OFS: pulse_ofs = cfg_data[VALUE_W-1:0];
          REG_IND_THR:   ind_thr   = cfg_data[VALUE_W-1:0];
          default: ;
        endcase
      end
      // result first: the output is registered, so it belongs to an earlier word
      if (out_valid && out_ready) begin
        got_w = {out_value, out_slot, out_written, out_frame_sync, out_indicator};
        if (channel_words_q.size() == 0) begin
          flag_mismatch($sformatf("word %0d: result with none expected", word_no));
        end else begin
          want_w = channel_words_q.pop_front();
          check_field("value", 16'(got_w.value), 16'(want_w.value));
          check_field("slot", 16'(got_w.slot), 16'(want_w.slot));
          check_field("written", 16'(got_w.written), 16'(want_w.written));
          check_field("frame_sync", 16'(got_w.frame_sync), 16'(want_w.frame_sync));
          check_field("indicator", 16'(got_w.indicator), 16'(want_w.indicator));
        end
        word_no++;
      end
      if (in_valid && in_ready) begin
        decode_word(in_req_type, in_capture_time, in_read_channel, next_w);
        channel_words_q.push_back(next_w);
      end
    end
    pending_words = channel_words_q.size();
  end

endmodule

@@ bench/ppm_frame_decoder_tb.sv @@
// Testbench top for the PPM frame decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module ppm_frame_decoder_tb;
  import ppmfd_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [TIME_W-1:0]     in_capture_time;
  logic [RCH_W-1:0]      in_read_channel;
  logic                  out_valid;
  logic                  out_ready;
  logic [VALUE_W-1:0]    out_value;
  logic [SLOT_W-1:0]     out_slot;
  logic                  out_written;
  logic                  out_frame_sync;
  logic                  out_indicator;

  int fail_cnt;
  int pending_cnt;

  int snd_idle_pct = 20;
  int rcv_idle_pct = 75;
  int hold_cycles  = 0;
  int sent_cnt     = 0;

  int sync_thr  = 6000;
  int pulse_ofs = 1000;
  int ind_thr   = 700;
  logic [TIME_W-1:0] last_cap = '0;

  ppm_frame_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_capture_time (in_capture_time),
    .in_read_channel (in_read_channel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_slot        (out_slot),
    .out_written     (out_written),
    .out_frame_sync  (out_frame_sync),
    .out_indicator   (out_indicator)
  );

  ppm_frame_decoder_chk i_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_capture_time (in_capture_time),
    .in_read_channel (in_read_channel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_slot        (out_slot),
    .out_written     (out_written),
    .out_frame_sync  (out_frame_sync),
    .out_indicator   (out_indicator),
    .fail_count      (fail_cnt),
    .pending_words   (pending_cnt)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, or a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic offer(input logic req, input logic [TIME_W-1:0] cap,
                       input logic [RCH_W-1:0] rch);
    if (sent_cnt < 650) begin
      snd_idle_pct = 20;
      rcv_idle_pct = 75;
    end else if (sent_cnt < 1300) begin
      snd_idle_pct = 75;
      rcv_idle_pct = 20;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_capture_time <= cap;
    in_read_channel <= rch;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic send_time(input logic [TIME_W-1:0] cap);
    last_cap = cap;
    offer(REQ_CAPTURE, cap, RCH_W'($urandom_range(3)));
  endtask

  task automatic send_gap(input int gap);
    send_time(last_cap + gap[TIME_W-1:0]);
  endtask

  task automatic send_read(input int ch);
    offer(REQ_READ, TIME_W'($urandom_range(65535)), ch[RCH_W-1:0]);
  endtask

  function automatic int channel_gap();
    int g;
    if ($urandom_range(9) < 4) return $urandom_range(sync_thr, 0);
    // aim near the indicator threshold
    g = 2 * pulse_ofs + 2 * ind_thr + int'($urandom_range(1200)) - 600;
    if (g < 0) g = 0;
    if (g > sync_thr) g = sync_thr;
    return g;
  endfunction

  function automatic int sync_gap();
    if (sync_thr >= 65535) return 65535;
    if ($urandom_range(9) < 3) return sync_thr + 1;
    return $urandom_range(65535, sync_thr + 1);
  endfunction

  task automatic send_frame();
    int nch;
    nch = ($urandom_range(9) < 6) ? 4 : $urandom_range(6);
    send_gap(sync_gap());
    for (int k = 0; k < nch; k++) begin
      send_gap(channel_gap());
      if ($urandom_range(4) == 0) send_read($urandom_range(3));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(input int s, input int o, input int i);
    drain_results();
    write_reg(REG_SYNC_THR, s);
    // bit 15 is unused by the 15-bit registers
    write_reg(REG_PULSE_OFS, o | ($urandom_range(1) << 15));
    write_reg(REG_IND_THR, i | ($urandom_range(1) << 15));
    cfg_valid <= 1'b0;
    sync_thr  = s;
    pulse_ofs = o;
    ind_thr   = i;
  endtask

  task automatic run_phase(input int n_words, input bit long_hold, input bit drain_mid);
    int first;
    int pick;
    bit mid_done;
    first    = sent_cnt;
    mid_done = 1'b0;
    while (sent_cnt - first < n_words) begin
      if (!mid_done && sent_cnt - first >= n_words / 2) begin
        mid_done = 1'b1;
        if (long_hold) hold_cycles = 80;
        if (drain_mid) drain_results();
      end
      pick = $urandom_range(99);
      if (pick < 70) send_frame();
      else if (pick < 85) send_read($urandom_range(3));
      else send_time(TIME_W'($urandom_range(65535)));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_req_type     = REQ_CAPTURE;
    in_capture_time = '0;
    in_read_channel = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    for (int ch = 0; ch < 4; ch++) send_read(ch);
    send_time(16'h0000);
    send_time(16'h0000);
    send_time(16'hFFFF);
    send_gap(4000);
    send_gap(2001);
    send_gap(6000);
    send_gap(1999);
    send_gap(3000);
    send_gap(6001);
    for (int ch = 0; ch < 4; ch++) send_read(ch);
    send_gap(2800);
    send_gap(0);

    set_regs(6000, 1000, 700);
    run_phase(320, 1'b0, 1'b0);
    set_regs(0, 0, 0);
    run_phase(320, 1'b0, 1'b1);
    set_regs(65535, 32767, 32767);
    run_phase(320, 1'b0, 1'b0);
    set_regs(65535, 0, 0);
    run_phase(320, 1'b0, 1'b0);
    set_regs(3000, 500, 32767);
    run_phase(320, 1'b1, 1'b0);
    set_regs($urandom_range(65534, 2000), $urandom_range(3000), $urandom_range(2000));
    run_phase(320, 1'b1, 1'b0);

    drain_results();
    repeat (5) @(negedge clk);
    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
